@@ hdl/shfd_pkg.sv @@
`default_nettype none
package shfd_pkg;

  localparam int FRAME_BYTES   = 43;
  localparam int PAYLOAD_BYTES = 40;
  localparam int WORD_COUNT    = 10;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;
  localparam int LANES         = WORD_W / BYTE_W;
  localparam int HEAD_BYTES    = 2;

  localparam int IDX_W      = $clog2(FRAME_BYTES);
  localparam int WORD_IDX_W = $clog2(WORD_COUNT);
  localparam int LANE_W     = $clog2(LANES);
  localparam int POS_W      = WORD_IDX_W + LANE_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC1,
    PH_COLLECT
  } phase_t;

  typedef enum logic {
    CMD_STORE,
    CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [POS_W-1:0]    pos;
    logic [BYTE_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

endpackage
`default_nettype wire

@@ hdl/shfd_in_if.sv @@
`default_nettype none
interface shfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/shfd_out_if.sv @@
`default_nettype none
interface shfd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] quat_w;
  logic [31:0] quat_x;
  logic [31:0] quat_y;
  logic [31:0] quat_z;
  logic [31:0] gyro_x;
  logic [31:0] gyro_y;
  logic [31:0] gyro_z;
  logic [31:0] accel_x;
  logic [31:0] accel_y;
  logic [31:0] accel_z;

  modport source (
    output valid, input ready,
    output quat_w, output quat_x, output quat_y, output quat_z,
    output gyro_x, output gyro_y, output gyro_z,
    output accel_x, output accel_y, output accel_z
  );
  modport sink (
    input valid, output ready,
    input quat_w, input quat_x, input quat_y, input quat_z,
    input gyro_x, input gyro_y, input gyro_z,
    input accel_x, input accel_y, input accel_z
  );
endinterface
`default_nettype wire

@@ hdl/shfd_front.sv @@
`default_nettype none
module shfd_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [shfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [shfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  shfd_in_if.sink                               in_if,
  input  wire logic                             q_full,
  output shfd_pkg::push_t                       q_push
);

  logic [shfd_pkg::BYTE_W-1:0] sync_first_r;
  logic [shfd_pkg::BYTE_W-1:0] sync_second_r;
  shfd_pkg::phase_t            phase_r, phase_nxt;
  logic [shfd_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [shfd_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic                        take;
  logic [shfd_pkg::BYTE_W-1:0] b;
  logic                        mid_frame;
  logic [shfd_pkg::IDX_W-1:0]  rel_idx;

  assign in_if.ready = !q_full;
  assign take        = in_if.valid && !q_full;
  assign b           = in_if.rx_byte;
  assign mid_frame   = idx_r < shfd_pkg::IDX_W'(shfd_pkg::FRAME_BYTES - 1);
  assign rel_idx     = idx_r - shfd_pkg::IDX_W'(shfd_pkg::HEAD_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= shfd_pkg::SYNC_FIRST_RST;
      sync_second_r <= shfd_pkg::SYNC_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shfd_pkg::REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        shfd_pkg::REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= shfd_pkg::PH_HUNT;
      idx_r   <= '0;
      xor_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = shfd_pkg::PH_HUNT;
    idx_nxt   = '0;
    xor_nxt   = '0;
    unique case (phase_r)
      shfd_pkg::PH_SYNC1: begin
        if (b == sync_second_r) begin
          phase_nxt = shfd_pkg::PH_COLLECT;
          idx_nxt   = shfd_pkg::IDX_W'(shfd_pkg::HEAD_BYTES);
          xor_nxt   = xor_r ^ b;
        end else if (b == sync_first_r) begin
          phase_nxt = shfd_pkg::PH_SYNC1;
          idx_nxt   = shfd_pkg::IDX_W'(1);
          xor_nxt   = b;
        end
      end
      shfd_pkg::PH_COLLECT: begin
        if (mid_frame) begin
          phase_nxt = shfd_pkg::PH_COLLECT;
          idx_nxt   = idx_r + shfd_pkg::IDX_W'(1);
          xor_nxt   = xor_r ^ b;
        end
      end
      default: begin
        if (b == sync_first_r) begin
          phase_nxt = shfd_pkg::PH_SYNC1;
          idx_nxt   = shfd_pkg::IDX_W'(1);
          xor_nxt   = b;
        end
      end
    endcase
  end

  // commands to the back end
  always_comb begin
    q_push.push     = 1'b0;
    q_push.cmd.op   = shfd_pkg::CMD_STORE;
    q_push.cmd.pos  = shfd_pkg::POS_W'(rel_idx);
    q_push.cmd.data = b;
    unique case (phase_r)
      shfd_pkg::PH_COLLECT: begin
        if (mid_frame) begin
          q_push.push = take && (rel_idx < shfd_pkg::IDX_W'(shfd_pkg::PAYLOAD_BYTES));
        end else begin
          q_push.push   = take && (xor_r == b);
          q_push.cmd.op = shfd_pkg::CMD_EMIT;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/shfd_queue.sv @@
`default_nettype none
module shfd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire shfd_pkg::push_t  q_push,
  output logic                  q_full,
  output logic                  head_valid,
  output shfd_pkg::cmd_t        head_cmd,
  input  wire logic             pop
);

  shfd_pkg::cmd_t                q_r [shfd_pkg::QUEUE_DEPTH];
  logic [shfd_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [shfd_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [shfd_pkg::QCNT_W-1:0]   cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign q_full     = cnt_r == shfd_pkg::QCNT_W'(shfd_pkg::QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = q_r[rd_ptr_r];
  assign do_push    = q_push.push && !q_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= q_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + shfd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + shfd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + shfd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - shfd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/shfd_back.sv @@
`default_nettype none
module shfd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire shfd_pkg::cmd_t  head_cmd,
  output logic                 pop,
  shfd_out_if.source           out_if
);

  logic [shfd_pkg::WORD_W-1:0] words_r [shfd_pkg::WORD_COUNT];
  logic [shfd_pkg::WORD_W-1:0] res_r   [shfd_pkg::WORD_COUNT];
  logic                        out_valid_r;
  logic                        slot_free;
  logic                        do_emit;
  logic                        do_store;

  assign slot_free = !out_valid_r || out_if.ready;
  assign do_store  = head_valid && (head_cmd.op == shfd_pkg::CMD_STORE);
  assign do_emit   = head_valid && (head_cmd.op == shfd_pkg::CMD_EMIT) && slot_free;
  assign pop       = do_store || do_emit;

  // payload bytes land in their word lane
  always_ff @(posedge clk) begin
    if (do_store) begin
      words_r[head_cmd.pos[shfd_pkg::POS_W-1:shfd_pkg::LANE_W]]
        [head_cmd.pos[shfd_pkg::LANE_W-1:0]*shfd_pkg::BYTE_W +: shfd_pkg::BYTE_W]
        <= head_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      res_r <= words_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.quat_w  = res_r[0];
  assign out_if.quat_x  = res_r[1];
  assign out_if.quat_y  = res_r[2];
  assign out_if.quat_z  = res_r[3];
  assign out_if.gyro_x  = res_r[4];
  assign out_if.gyro_y  = res_r[5];
  assign out_if.gyro_z  = res_r[6];
  assign out_if.accel_x = res_r[7];
  assign out_if.accel_y = res_r[8];
  assign out_if.accel_z = res_r[9];

endmodule
`default_nettype wire

@@ hdl/sync_header_frame_deframer.sv @@
// channel  | dir | handshake    | payload
// in_if    | in  | valid/ready  | rx_byte (8)
// out_if   | out | valid/ready  | quat_w..z, gyro_x..z, accel_x..z (32 each)
// cfg      | in  | cfg_we       | cfg_index (1), cfg_wdata (8)
//
// one byte per cycle while in_if.ready is high; results go via queue and output reg
// sync hunt and checksum run in the front end, payload assembly in the back end
// a two-entry command queue lets the front keep taking bytes while a result waits
// in_if.ready drops only once the queue is full behind a stalled result
// synchronous active-low reset; no clearing pass
`default_nettype none
module sync_header_frame_deframer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [shfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [shfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  shfd_in_if.sink                               in_if,
  shfd_out_if.source                            out_if
);

  shfd_pkg::push_t q_push;
  logic            q_full;
  logic            head_valid;
  shfd_pkg::cmd_t  head_cmd;
  logic            pop;

  shfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  shfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_push     (q_push),
    .q_full     (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  shfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_if     (out_if)
  );

endmodule
`default_nettype wire

@@ hdl/shfd_checker.sv @@
`default_nettype none
module shfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_quat_w
);

  // no result straight out of reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input backpressure only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_quat_w))
    else $error("result changed while stalled");

endmodule

bind sync_header_frame_deframer shfd_checker u_shfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_quat_w (out_if.quat_w)
);
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;

  typedef logic [shfd_pkg::WORD_COUNT-1:0][shfd_pkg::WORD_W-1:0] frame_words_t;
  typedef enum {FILL_CONST, FILL_RAMP, FILL_RAND} fill_t;

  typedef struct {
    bit          false_start;
    logic [7:0]  lead;
    int          n_lead;
    bit          dbl_first;
    fill_t       fill;
    logic [7:0]  fill_val;
    bit          bad_sum;
    bit          typed;
    bit          exp_hit;
    logic [31:0] exp_word;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [shfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [shfd_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            recv_ready = 1'b0;

  shfd_in_if  in_ch ();
  shfd_out_if out_ch ();

  assign out_ch.ready = recv_ready;

  sync_header_frame_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [7:0]        sync_first_q  = shfd_pkg::SYNC_FIRST_RST;
  logic [7:0]        sync_second_q = shfd_pkg::SYNC_SECOND_RST;
  shfd_pkg::phase_t  rx_phase = shfd_pkg::PH_HUNT;
  logic [5:0]        rx_idx = '0;
  logic [7:0]        rx_sum = '0;
  logic [7:0]        rx_payload [shfd_pkg::PAYLOAD_BYTES];

  frame_words_t expected_frames [$];
  logic [7:0]   stim_bytes [$];
  int           frames_predicted = 0;
  int           bytes_sent = 0;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           typed_active = 1'b0;
  bit           typed_hit = 1'b0;
  frame_words_t typed_words;
  string        field_names [shfd_pkg::WORD_COUNT] =
                  '{"quat_w", "quat_x", "quat_y", "quat_z",
                    "gyro_x", "gyro_y", "gyro_z",
                    "accel_x", "accel_y", "accel_z"};

  task automatic hunt_restart();
    rx_phase = shfd_pkg::PH_HUNT;
    rx_idx   = '0;
    rx_sum   = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit done, output bit hit,
                              output frame_words_t w);
    int pos;
    done = 1'b0;
    hit  = 1'b0;
    w    = '0;
    case (rx_phase)
      shfd_pkg::PH_SYNC1: begin
        if (b == sync_second_q) begin
          rx_sum   = rx_sum ^ b;
          rx_idx   = 6'(shfd_pkg::HEAD_BYTES);
          rx_phase = shfd_pkg::PH_COLLECT;
        end else if (b == sync_first_q) begin
          rx_sum = b;
          rx_idx = 6'd1;
        end else begin
          hunt_restart();
        end
      end
      shfd_pkg::PH_COLLECT: begin
        pos = int'(rx_idx);
        if (pos + 1 < shfd_pkg::FRAME_BYTES) begin
          if (pos >= shfd_pkg::HEAD_BYTES &&
              pos - shfd_pkg::HEAD_BYTES < shfd_pkg::PAYLOAD_BYTES)
            rx_payload[pos - shfd_pkg::HEAD_BYTES] = b;
          rx_sum = rx_sum ^ b;
          rx_idx = rx_idx + 6'd1;
        end else begin
          done = 1'b1;
          hit  = (rx_sum == b);
          if (hit) begin
            for (int k = 0; k < shfd_pkg::WORD_COUNT; k++)
              for (int j = 0; j < shfd_pkg::LANES; j++)
                w[k][8*j +: 8] = rx_payload[shfd_pkg::LANES*k + j];
          end
          hunt_restart();
        end
      end
      default: begin
        if (b == sync_first_q) begin
          rx_sum   = b;
          rx_idx   = 6'd1;
          rx_phase = shfd_pkg::PH_SYNC1;
        end else begin
          hunt_restart();
        end
      end
    endcase
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 12) return sync_first_q;
    if (r < 22) return sync_second_q;
    if (r < 30) return 8'h00;
    if (r < 38) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic append_frame(input fill_t fill, input logic [7:0] val, input bit bad,
                              input bit dbl);
    logic [7:0] sum;
    logic [7:0] b;
    sum = sync_first_q ^ sync_second_q;
    if (dbl) stim_bytes.push_back(sync_first_q);
    stim_bytes.push_back(sync_first_q);
    stim_bytes.push_back(sync_second_q);
    for (int i = 0; i < shfd_pkg::PAYLOAD_BYTES; i++) begin
      case (fill)
        FILL_CONST: b = val;
        FILL_RAMP:  b = val + 8'(i);
        default:    b = pick_byte();
      endcase
      stim_bytes.push_back(b);
      sum = sum ^ b;
    end
    stim_bytes.push_back(bad ? sum ^ (8'h01 << $urandom_range(7)) : sum);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    bit           done;
    bit           hit;
    frame_words_t w;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    deframe_byte(b, done, hit, w);
    if (hit) frames_predicted++;
    if (typed_active) begin
      if (done && typed_hit) expected_frames.push_back(typed_words);
    end else if (hit) begin
      expected_frames.push_back(w);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic send_stim();
    while (stim_bytes.size() > 0) feed_byte(stim_bytes.pop_front());
  endtask

  task automatic settle_and_drain();
    logic [7:0] filler;
    filler = 8'h00;
    while (filler == sync_first_q || filler == sync_second_q) filler++;
    while (rx_phase != shfd_pkg::PH_HUNT) feed_byte(filler);
    in_ch.valid <= 1'b0;
    while (expected_frames.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_syncs(input logic [7:0] first, input logic [7:0] second);
    cfg_we    <= 1'b1;
    cfg_index <= shfd_pkg::REG_SYNC_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    sync_first_q = first;
    cfg_index <= shfd_pkg::REG_SYNC_SECOND;
    cfg_wdata <= second;
    @(posedge clk);
    sync_second_q = second;
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 26; recv_idle_pct = 51; end
      1: begin send_idle_pct = 51; recv_idle_pct = 26; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  task automatic run_phase(input logic [7:0] first, input logic [7:0] second);
    int start_frames;
    int start_bytes;
    int r;
    write_syncs(first, second);
    start_frames = frames_predicted;
    start_bytes  = bytes_sent;
    while (frames_predicted - start_frames < 3 || bytes_sent - start_bytes < 160) begin
      r = $urandom_range(99);
      if (r < 80) begin
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) stim_bytes.push_back(pick_byte());
        append_frame(FILL_RAND, 8'h00, $urandom_range(9) == 0, $urandom_range(9) == 0);
      end else if (r < 90) begin
        // broken header or a frame cut short
        stim_bytes.push_back(sync_first_q);
        if ($urandom_range(1)) begin
          stim_bytes.push_back(sync_second_q);
          repeat ($urandom_range(1, 12)) stim_bytes.push_back(pick_byte());
        end else begin
          stim_bytes.push_back(pick_byte());
        end
      end else begin
        repeat ($urandom_range(1, 8)) stim_bytes.push_back(8'($urandom));
      end
      send_stim();
    end
    settle_and_drain();
  endtask

  task automatic check_frame();
    frame_words_t act;
    frame_words_t exp_w;
    act = {out_ch.accel_z, out_ch.accel_y, out_ch.accel_x,
           out_ch.gyro_z, out_ch.gyro_y, out_ch.gyro_x,
           out_ch.quat_z, out_ch.quat_y, out_ch.quat_x, out_ch.quat_w};
    if (expected_frames.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual quat_w=%h accel_z=%h",
               $time, act[0], act[shfd_pkg::WORD_COUNT-1]);
      errors++;
    end else begin
      exp_w = expected_frames.pop_front();
      for (int k = 0; k < shfd_pkg::WORD_COUNT; k++) begin
        if (act[k] !== exp_w[k]) begin
          $display("%0t: %s expected %h actual %h", $time, field_names[k], exp_w[k], act[k]);
          errors++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_frame();
    recv_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #1_000_000;
    $display("sync_header_frame_deframer verification failed");
    $finish;
  end

  initial begin
    dir_row_t   dir_rows [11];
    logic [7:0] first;
    logic [7:0] second;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = shfd_pkg::REG_SYNC_FIRST;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    dir_rows = '{
      '{0, 8'h00, 0, 0, FILL_CONST, 8'h00, 0, 1, 1, 32'h0000_0000},
      '{0, 8'h00, 0, 0, FILL_CONST, 8'hFF, 0, 1, 1, 32'hFFFF_FFFF},
      '{0, 8'h00, 0, 0, FILL_CONST, 8'hAA, 0, 1, 1, 32'hAAAA_AAAA},
      '{0, 8'h00, 0, 0, FILL_CONST, 8'h55, 1, 1, 0, 32'h0000_0000},
      '{0, 8'hFF, 2, 1, FILL_CONST, 8'h5A, 0, 1, 1, 32'h5A5A_5A5A},
      '{1, 8'h00, 3, 0, FILL_CONST, 8'h01, 0, 1, 1, 32'h0101_0101},
      '{0, 8'h00, 0, 0, FILL_RAMP,  8'h00, 0, 0, 0, 32'h0000_0000},
      '{1, 8'h7E, 1, 1, FILL_RAMP,  8'hC0, 0, 0, 0, 32'h0000_0000},
      '{0, 8'h00, 0, 0, FILL_RAND,  8'h00, 1, 0, 0, 32'h0000_0000},
      '{0, 8'h00, 1, 0, FILL_RAND,  8'h00, 0, 0, 0, 32'h0000_0000},
      '{0, 8'h00, 2, 0, FILL_CONST, 8'h80, 0, 1, 1, 32'h8080_8080}
    };
    set_idle(0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sync values, table of frames
    foreach (dir_rows[i]) begin
      if (dir_rows[i].false_start) stim_bytes.push_back(sync_first_q);
      repeat (dir_rows[i].n_lead) stim_bytes.push_back(dir_rows[i].lead);
      append_frame(dir_rows[i].fill, dir_rows[i].fill_val, dir_rows[i].bad_sum,
                   dir_rows[i].dbl_first);
      typed_active = dir_rows[i].typed;
      typed_hit    = dir_rows[i].exp_hit;
      typed_words  = {shfd_pkg::WORD_COUNT{dir_rows[i].exp_word}};
      send_stim();
    end
    typed_active = 1'b0;
    settle_and_drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin first = 8'hAA; second = 8'h55; end
        1: begin first = 8'h00; second = 8'hFF; end
        2: begin first = 8'hFF; second = 8'h00; end
        3: begin first = 8'h3C; second = 8'h3C; end
        4: begin first = 8'($urandom); second = 8'($urandom); end
        default: begin first = 8'h55; second = 8'hAA; end
      endcase
      set_idle(p / 2);
      run_phase(first, second);
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("sync_header_frame_deframer verification clean");
    end else begin
      $display("sync_header_frame_deframer verification failed");
    end
    $finish;
  end
endmodule
